// File: hw/rtl/dc_motor_pi_position_loop_macros.svh
// Assertion macros used by the position loop checker.
`ifndef DC_MOTOR_PI_POSITION_LOOP_MACROS_SVH
`define DC_MOTOR_PI_POSITION_LOOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define DCPI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcpi implication check failed");

// Next-cycle implication, masked while rst is high.
`define DCPI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcpi next-cycle check failed");

`endif

// File: hw/rtl/dcpi_pkg.sv
// Types and constants for the DC motor PI position loop.
package dcpi_pkg;

   localparam int COUNT_WIDTH_DEF = 24;
   localparam int GAIN_FRAC_DEF   = 8;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 64;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 23;

   // request kinds carried on req_tuser
   typedef enum logic [2:0] {
      REQ_START = 3'd0,
      REQ_EDGE  = 3'd1,
      REQ_TICK  = 3'd2,
      REQ_DUTY  = 3'd3,
      REQ_STOP  = 3'd4
   } req_kind_type;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_INT_LIMIT  = 3'd2,
      CSR_MIN_DUTY   = 3'd3,
      CSR_MAX_DUTY   = 3'd4,
      CSR_DEAD_BAND  = 3'd5
   } csr_index_type;

   localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
   localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
   localparam logic [22:0] INT_LIMIT_RST  = 23'd1000;
   localparam logic [7:0]  MIN_DUTY_RST   = 8'd0;
   localparam logic [7:0]  MAX_DUTY_RST   = 8'd255;
   localparam logic [7:0]  DEAD_BAND_RST  = 8'd2;

   // request payload, lowest field in the lowest bits
   typedef struct packed {
      logic [6:0]         pad;
      logic               direction_in;
      logic [7:0]         duty_in;
      logic signed [23:0] target_pulses;
   } req_data_type;

   // status payload, lowest field in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic signed [23:0] integral_out;
      logic signed [23:0] pulses_left;
      logic               move_done;
      logic               drive_enabled;
      logic               reverse_out;
      logic [7:0]         duty_out;
   } rsp_data_type;

endpackage

// File: hw/rtl/dc_motor_pi_position_loop.sv
// DC motor position loop: request decode, PI tick datapath and status output.
//
// Each request transfer (start move, encoder edge, control tick, set duty, stop;
// kind on req_tuser) returns exactly one status transfer holding the state
// after that request. One request is taken every clock cycle unless the output
// stalls; it passes the input register, then the status register. The critical
// path is the control tick: integral add and clamp, the two gain multiplies in
// parallel, their sum, magnitude, fraction shift and duty clamp all settle
// before the loop state updates, so the next request sees the updated state.
// The input register takes one request while a status waits on rsp_tready; a
// full one with a stalled output drops req_tready. Configuration writes
// on the csr port take effect at once and are meant to happen while idle.
// Gains are unsigned with GAIN_FRAC_BITS fraction bits; the loop count is a
// signed COUNT_WIDTH value, reported sign-extended or truncated to 24 bits.
module dc_motor_pi_position_loop #(
   parameter int COUNT_WIDTH    = dcpi_pkg::COUNT_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = dcpi_pkg::GAIN_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: target_pulses[23:0], duty_in[31:24], direction_in[32], zero pad
   input  logic [dcpi_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: req_type[2:0]
   input  logic [2:0]                         req_tuser,
   // status channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: duty_out[7:0], reverse_out[8], drive_enabled[9], move_done[10],
   //        pulses_left[34:11], integral_out[58:35], zero pad
   output logic [dcpi_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // configuration write port
   input  logic                               csr_we,
   input  logic [dcpi_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [dcpi_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = COUNT_WIDTH;
   localparam int PW = CW + 17;                  // gain (17b signed) x count
   localparam int UW = CW + 18;                  // sum of two products
   localparam int XW = (CW > 24) ? CW + 1 : 25;  // compare width vs 24b values

   localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

   // ---------------------------------------------------------------- config
   logic [15:0] prop_gain_ff, integ_gain_ff;
   logic [22:0] int_limit_ff;
   logic [7:0]  min_duty_ff, max_duty_ff, dead_band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= dcpi_pkg::PROP_GAIN_RST;
         integ_gain_ff <= dcpi_pkg::INTEG_GAIN_RST;
         int_limit_ff  <= dcpi_pkg::INT_LIMIT_RST;
         min_duty_ff   <= dcpi_pkg::MIN_DUTY_RST;
         max_duty_ff   <= dcpi_pkg::MAX_DUTY_RST;
         dead_band_ff  <= dcpi_pkg::DEAD_BAND_RST;
      end else if (csr_we) begin
         case (csr_addr)
            dcpi_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata[15:0];
            dcpi_pkg::CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata[15:0];
            dcpi_pkg::CSR_INT_LIMIT:  int_limit_ff  <= csr_wdata[22:0];
            dcpi_pkg::CSR_MIN_DUTY:   min_duty_ff   <= csr_wdata[7:0];
            dcpi_pkg::CSR_MAX_DUTY:   max_duty_ff   <= csr_wdata[7:0];
            dcpi_pkg::CSR_DEAD_BAND:  dead_band_ff  <= csr_wdata[7:0];
            default: ;   // writes past the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   dcpi_pkg::req_data_type req_data;
   logic                   in_valid_ff, in_valid_in;
   logic [2:0]             in_kind_ff;
   logic signed [23:0]     in_target_ff;
   logic [7:0]             in_duty_ff;
   logic                   in_dir_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance, req_take;

   assign req_data   = dcpi_pkg::req_data_type'(req_tdata);
   // the held request moves on when the status register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= req_tuser;
         in_target_ff <= req_data.target_pulses;
         in_duty_ff   <= req_data.duty_in;
         in_dir_ff    <= req_data.direction_in;
      end
   end

   // ----------------------------------------------------------- loop state
   logic signed [CW-1:0] remaining_ff, remaining_in;
   logic signed [CW-1:0] integral_ff, integral_in;
   logic                 reverse_ff, reverse_in;
   logic                 done_ff, done_in;
   logic [7:0]           duty_reg_ff, duty_reg_in;
   logic                 enable_ff, enable_in;

   // start: saturate the 24b target into the count range
   logic signed [XW-1:0] tgt_x;
   logic signed [CW-1:0] tgt_sat;

   always_comb begin
      tgt_x = XW'(in_target_ff);
      if (tgt_x > XW'(CNT_MAX))      tgt_sat = CNT_MAX;
      else if (tgt_x < XW'(CNT_MIN)) tgt_sat = CNT_MIN;
      else                           tgt_sat = CW'(tgt_x);
   end

   // encoder edge: step the count down when driving forward, up in reverse, saturating
   logic signed [CW:0]   edge_x;
   logic signed [CW-1:0] edge_cnt;

   always_comb begin
      if (reverse_ff) edge_x = (CW+1)'(remaining_ff) + (CW+1)'(1);
      else            edge_x = (CW+1)'(remaining_ff) - (CW+1)'(1);
      if (edge_x > (CW+1)'(CNT_MAX))      edge_cnt = CNT_MAX;
      else if (edge_x < (CW+1)'(CNT_MIN)) edge_cnt = CNT_MIN;
      else                                edge_cnt = CW'(edge_x);
   end

   // control tick: integral update and clamp
   logic signed [XW-1:0] lim_x;
   logic signed [CW:0]   lim_w;
   logic signed [CW:0]   isum_x;
   logic signed [CW-1:0] isum_new;

   always_comb begin
      lim_x = XW'($signed({1'b0, int_limit_ff}));
      if (lim_x > XW'(CNT_MAX)) lim_w = (CW+1)'(CNT_MAX);
      else                      lim_w = (CW+1)'(lim_x);
      isum_x = (CW+1)'(integral_ff) + (CW+1)'(remaining_ff);
      if (isum_x > lim_w)       isum_new = CW'(lim_w);
      else if (isum_x < -lim_w) isum_new = CW'(-lim_w);
      else                      isum_new = CW'(isum_x);
   end

   // control tick: PI sum, sign, magnitude, duty clamp
   logic signed [16:0]   kp_s, ki_s;
   logic signed [PW-1:0] prod_p, prod_i;
   logic signed [UW-1:0] u_sum;
   logic [UW-1:0]        mag, mag_sh;
   logic [7:0]           tick_duty;
   logic [CW:0]          abs_rem;
   logic                 in_band;

   always_comb begin
      kp_s   = $signed({1'b0, prop_gain_ff});
      ki_s   = $signed({1'b0, integ_gain_ff});
      prod_p = kp_s * remaining_ff;
      prod_i = ki_s * isum_new;
      u_sum  = UW'(prod_p) + UW'(prod_i);
      mag    = u_sum[UW-1] ? UW'(-u_sum) : UW'(u_sum);
      mag_sh = mag >> GAIN_FRAC_BITS;
      // min test first: with min above max the min wins below min
      if (mag_sh < UW'(min_duty_ff))      tick_duty = min_duty_ff;
      else if (mag_sh > UW'(max_duty_ff)) tick_duty = max_duty_ff;
      else                                tick_duty = mag_sh[7:0];
      if (remaining_ff[CW-1]) abs_rem = -((CW+1)'(remaining_ff));
      else                    abs_rem = (CW+1)'(remaining_ff);
      in_band = abs_rem <= (CW+1)'(dead_band_ff);
   end

   // next state per request kind
   always_comb begin
      remaining_in = remaining_ff;
      integral_in  = integral_ff;
      reverse_in   = reverse_ff;
      done_in      = done_ff;
      duty_reg_in  = duty_reg_ff;
      enable_in    = enable_ff;
      case (in_kind_ff)
         dcpi_pkg::REQ_START: begin
            remaining_in = tgt_sat;
            duty_reg_in  = in_duty_ff;
            reverse_in   = in_dir_ff;
            enable_in    = 1'b1;
            done_in      = 1'b0;
         end
         dcpi_pkg::REQ_EDGE: begin
            remaining_in = edge_cnt;
         end
         dcpi_pkg::REQ_TICK: begin
            if (!done_ff) begin
               reverse_in  = u_sum[UW-1];
               duty_reg_in = tick_duty;
               if (in_band) begin
                  done_in     = 1'b1;
                  enable_in   = 1'b0;
                  integral_in = '0;
               end else begin
                  integral_in = isum_new;
               end
            end
         end
         dcpi_pkg::REQ_DUTY: begin
            duty_reg_in = in_duty_ff;
         end
         dcpi_pkg::REQ_STOP: begin
            enable_in = 1'b0;
         end
         default: ;   // unknown kinds only report status
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         integral_ff  <= '0;
         reverse_ff   <= 1'b0;
         done_ff      <= 1'b0;
         duty_reg_ff  <= '0;
         enable_ff    <= 1'b0;
      end else if (advance) begin
         remaining_ff <= remaining_in;
         integral_ff  <= integral_in;
         reverse_ff   <= reverse_in;
         done_ff      <= done_in;
         duty_reg_ff  <= duty_reg_in;
         enable_ff    <= enable_in;
      end
   end

   // --------------------------------------------------------- status stage
   dcpi_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.duty_out      = duty_reg_in;
      rsp_data_in.reverse_out   = reverse_in;
      rsp_data_in.drive_enabled = enable_in;
      rsp_data_in.move_done     = done_in;
      rsp_data_in.pulses_left   = 24'(remaining_in);
      rsp_data_in.integral_out  = 24'(integral_in);
   end

   always_comb begin
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dcpi_pkg::RSP_TDATA_W'(rsp_data_ff);

endmodule

// File: hw/rtl/dcpi_checker.sv
// Port-level checks for the position loop, bound to the top level.
`include "dc_motor_pi_position_loop_macros.svh"

module dcpi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dcpi_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   dcpi_pkg::rsp_data_type rsp;

   assign rsp = dcpi_pkg::rsp_data_type'(rsp_tdata);

   // a status waiting on the sink stays offered
   `DCPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // no status transfer right out of reset
   `DCPI_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)
   // a finished move always has the drive off
   `DCPI_ASSERT_IMPL(a_done_off, clock, reset, rsp_tvalid && rsp.move_done,
                     !rsp.drive_enabled)
   // a finished move leaves the integral cleared
   `DCPI_ASSERT_IMPL(a_done_int, clock, reset, rsp_tvalid && rsp.move_done,
                     rsp.integral_out == 24'sd0)

endmodule

bind dc_motor_pi_position_loop dcpi_checker u_dcpi_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
